[hw/rtl/linear_probing_hash_set_assert.svh]
// Assertion macros for the hash set checker.
`ifndef LINEAR_PROBING_HASH_SET_ASSERT_SVH
`define LINEAR_PROBING_HASH_SET_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define LPHS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define LPHS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lphs_pkg.sv]
// Shared constants and controller/datapath interface types for the hash set.
package lphs_pkg;

    localparam int          TABLE_BITS_DEF = 10;
    localparam int          COUNT_W        = 11;
    localparam logic [31:0] HASH_MULT      = 32'd2654435761;
    localparam logic [31:0] EMPTY_SLOT     = 32'hFFFF_FFFF;

    // Request action codes; the unused code behaves as a lookup.
    localparam logic [1:0]  ACT_INSERT = 2'd1;
    localparam logic [1:0]  ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic load;         // capture action and folded key
        logic hash;         // register the hash product
        logic home;         // start the probe at the home slot
        logic rd;           // read the slot at the probe position
        logic advance;      // step to the next slot
        logic ins_write;    // store the key at the probe position
        logic sweep_start;  // restart the clearing sweep, zero the count
        logic sweep_write;  // empty one slot of the sweep
        logic res_load;     // load the result register
        logic res_present;
        logic res_inserted;
        logic res_full;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;        // slot read holds the empty pattern
        logic match;        // slot read holds the key
        logic last_probe;   // every slot has now been visited
        logic sweep_last;   // sweep is at the last slot
        logic is_insert;    // captured request is an insert
    } dp_status_t;

endpackage

[hw/rtl/lphs_datapath.sv]
// Hash set datapath: slot memory, hash, probe pointer, entry count and result register.
module lphs_datapath
    import lphs_pkg::*;
#(
    parameter int TABLE_BITS = TABLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         in_action,
    input  logic [31:0]        in_value,
    input  dp_cmd_t            cmd,
    output dp_status_t         st,
    output logic               res_present,
    output logic               res_inserted,
    output logic               res_full,
    output logic [COUNT_W-1:0] res_count
);

    localparam int SLOTS = 1 << TABLE_BITS;

    logic [31:0]            slot_mem [SLOTS];
    logic [31:0]            rd_data_reg;

    logic [1:0]             action_reg,  action_next;
    logic [31:0]            key_reg,     key_next;
    logic [31:0]            prod_reg,    prod_next;
    logic [TABLE_BITS-1:0]  pos_reg,     pos_next;
    logic [TABLE_BITS-1:0]  visited_reg, visited_next;
    logic [TABLE_BITS-1:0]  clr_addr_reg, clr_addr_next;
    logic [COUNT_W-1:0]     count_reg,   count_next;
    logic                   present_reg, present_next;
    logic                   inserted_reg, inserted_next;
    logic                   full_reg,    full_next;
    logic [COUNT_W-1:0]     rcount_reg,  rcount_next;

    logic                   mem_we;
    logic [TABLE_BITS-1:0]  mem_waddr;
    logic [31:0]            mem_wdata;

    always_comb
    begin
        action_next   = action_reg;
        key_next      = key_reg;
        prod_next     = prod_reg;
        pos_next      = pos_reg;
        visited_next  = visited_reg;
        clr_addr_next = clr_addr_reg;
        count_next    = count_reg;
        present_next  = present_reg;
        inserted_next = inserted_reg;
        full_next     = full_reg;
        rcount_next   = rcount_reg;

        if (cmd.load)
        begin
            action_next = in_action;
            // The empty pattern can never be a key, so it folds to zero.
            key_next    = (in_value == EMPTY_SLOT) ? 32'd0 : in_value;
        end
        if (cmd.hash)
        begin
            // Only the low word of the product feeds the home slot.
            prod_next = 32'(key_reg * HASH_MULT);
        end
        if (cmd.home)
        begin
            pos_next     = prod_reg[31 -: TABLE_BITS];
            visited_next = '0;
        end
        if (cmd.advance)
        begin
            pos_next     = pos_reg + TABLE_BITS'(1);
            visited_next = visited_reg + TABLE_BITS'(1);
        end
        if (cmd.sweep_start)
        begin
            clr_addr_next = '0;
            count_next    = '0;
        end
        if (cmd.sweep_write)
        begin
            clr_addr_next = clr_addr_reg + TABLE_BITS'(1);
        end
        if (cmd.ins_write)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        if (cmd.res_load)
        begin
            present_next  = cmd.res_present;
            inserted_next = cmd.res_inserted;
            full_next     = cmd.res_full;
            rcount_next   = cmd.ins_write ? count_reg + COUNT_W'(1) : count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        key_reg      <= key_next;
        prod_reg     <= prod_next;
        pos_reg      <= pos_next;
        visited_reg  <= visited_next;
        present_reg  <= present_next;
        inserted_reg <= inserted_next;
        full_reg     <= full_next;
        rcount_reg   <= rcount_next;
    end

    assign mem_we    = cmd.sweep_write | cmd.ins_write;
    assign mem_waddr = cmd.sweep_write ? clr_addr_reg : pos_reg;
    assign mem_wdata = cmd.sweep_write ? EMPTY_SLOT : key_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= slot_mem[pos_reg];
        end
    end

    assign st.empty      = (rd_data_reg == EMPTY_SLOT);
    assign st.match      = (rd_data_reg == key_reg);
    assign st.last_probe = (visited_reg == {TABLE_BITS{1'b1}});
    assign st.sweep_last = (clr_addr_reg == {TABLE_BITS{1'b1}});
    assign st.is_insert  = (action_reg == ACT_INSERT);

    assign res_present  = present_reg;
    assign res_inserted = inserted_reg;
    assign res_full     = full_reg;
    assign res_count    = rcount_reg;

endmodule

[hw/rtl/lphs_ctrl.sv]
// Hash set controller: sequences sweep, hash and probe steps and owns the handshakes.
module lphs_ctrl
    import lphs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_action,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_HASH,
        ST_HOME,
        ST_PROBE,
        ST_CHECK,
        ST_CLRDONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   clr_req_reg, clr_req_next;
    logic   out_free;
    logic   finish;

    assign out_free = !out_valid_reg || out_ready;
    assign finish   = st.empty || st.match || st.last_probe;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        clr_req_next   = clr_req_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;

        case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep_write = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = clr_req_reg ? ST_CLRDONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_action == ACT_CLEAR)
                    begin
                        cmd.sweep_start = 1'b1;
                        clr_req_next    = 1'b1;
                        state_next      = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                cmd.hash   = 1'b1;
                state_next = ST_HOME;
            end
            ST_HOME:
            begin
                cmd.home   = 1'b1;
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!finish)
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_PROBE;
                end
                else if (out_free)
                begin
                    // The store happens only together with the result, so a
                    // stalled result never writes twice.
                    cmd.ins_write    = st.empty && st.is_insert;
                    cmd.res_load     = 1'b1;
                    cmd.res_present  = st.match && !st.empty;
                    cmd.res_inserted = st.empty && st.is_insert;
                    cmd.res_full     = !st.match && !st.empty;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_CLRDONE:
            begin
                if (out_free)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    clr_req_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            out_valid_reg <= 1'b0;
            clr_req_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            clr_req_reg   <= clr_req_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/linear_probing_hash_set.sv]
// Top level of the linear-probing hash set of 32-bit keys.
// Requests arrive on the s_axis channel: tuser carries the action (lookup,
// insert if absent, clear) and tdata the 32-bit value. Each request gives
// exactly one result on the m_axis channel with the present, inserted and
// table_full flags and the entry count after the request.
// A lookup or insert first hashes the key (ST_HASH) and moves to the home slot
// (ST_HOME), then probes slot by slot, a memory read (ST_PROBE) then a compare
// (ST_CHECK). No new request is taken before the result is loaded, and
// s_axis_tready rises again together with the result valid.
// A clear, and the release of reset, run a sweep that empties one slot per
// cycle over all 2**TABLE_BITS slots (1024 at the default), during which
// s_axis_tready stays low; a clear then returns its all-zero result.
// The result sits in an output register. While the receiver stalls, the
// next request is still accepted and worked on, and it waits at its final
// compare until the held result has been taken.
module linear_probing_hash_set
    import lphs_pkg::*;
#(
    parameter int TABLE_BITS = TABLE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] present, [1] inserted, [2] table_full,
                                        // [13:3] entry_count, [15:14] zero
);

    dp_cmd_t            cmd;
    dp_status_t         st;
    logic               res_present;
    logic               res_inserted;
    logic               res_full;
    logic [COUNT_W-1:0] res_count;

    // The controller decides every step; the datapath reports slot contents
    // and sweep/probe progress back to it.
    lphs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .st        (st),
        .cmd       (cmd)
    );

    lphs_datapath #(
        .TABLE_BITS (TABLE_BITS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_action    (s_axis_tuser),
        .in_value     (s_axis_tdata),
        .cmd          (cmd),
        .st           (st),
        .res_present  (res_present),
        .res_inserted (res_inserted),
        .res_full     (res_full),
        .res_count    (res_count)
    );

    // Result fields packed from the lowest bit up, padded to two bytes.
    assign m_axis_tdata = {2'b00, res_count, res_full, res_inserted, res_present};

endmodule

[hw/rtl/lphs_checker.sv]
// Port-level checker for the hash set, bound to the top level.
`include "linear_probing_hash_set_assert.svh"

module lphs_checker
    import lphs_pkg::*;
#(
    parameter int TABLE_BITS = TABLE_BITS_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(1 << TABLE_BITS);

    logic s_take;
    logic m_hold;
    logic clear_take;

    assign s_take     = s_axis_tvalid && s_axis_tready;
    assign m_hold     = m_axis_tvalid && !m_axis_tready;
    assign clear_take = s_take && (s_axis_tuser == ACT_CLEAR);

    // A stalled result keeps its value.
    `LPHS_ASSERT_NXT(a_hold_result, m_hold, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // A stored key was absent and a slot was free, so no other flag goes with it.
    `LPHS_ASSERT_IMP(a_flags_excl, m_axis_tvalid && m_axis_tdata[1], !m_axis_tdata[0] && !m_axis_tdata[2], "inserted together with present or table_full")

    // A full table means every slot holds a key.
    `LPHS_ASSERT_IMP(a_full_count, m_axis_tvalid && m_axis_tdata[2] && (TABLE_BITS <= 10), m_axis_tdata[13:3] == FULL_COUNT, "table_full with a count below the table size")

    // The block works on one request at a time, so a request is never taken back to back.
    `LPHS_ASSERT_NXT(a_one_at_time, s_take, !s_axis_tready, "request accepted in consecutive cycles")

    // A clear starts its sweep, which holds off further requests.
    `LPHS_ASSERT_NXT(a_clear_sweep, clear_take, !s_axis_tready, "request accepted right after a clear")

endmodule

bind linear_probing_hash_set lphs_checker #(.TABLE_BITS(TABLE_BITS)) u_lphs_checker (.*);
